/* rtl/core/segment_to_bar_vertices_defines.svh */
// Assertion macros for the bar vertex checker.
`ifndef SEGMENT_TO_BAR_VERTICES_DEFINES_SVH
`define SEGMENT_TO_BAR_VERTICES_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BVX_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bar vertex check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BVX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bar vertex check failed");

`endif

/* rtl/core/bvx_pkg.sv */
// Shared types, constants and the slot table of the bar vertex block.
`timescale 1ns / 1ps
package bvx_pkg;
	localparam logic [4:0]  LAST_SLOT = 5'd23;
	localparam logic [30:0] HW_RESET  = 31'd655;

	// Bit positions of a slot code.
	localparam int unsigned CMB_SUB = 0;
	localparam int unsigned CMB_T2  = 1;
	localparam int unsigned CMB_P2  = 2;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [33:0] off_t;

	typedef struct packed {
		coord_t [2:0] p1;
		coord_t [2:0] p2;
		off_t   [2:0] o1;
		off_t   [2:0] o2;
		logic         degen;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIT,
		ST_CROSS,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_MUL,
		ST_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		FIT_D,
		FIT_T1,
		FIT_T2
	} fit_sel_t;

	function automatic logic [2:0] slot_combo(input logic [4:0] slot);
		logic [2:0] c;
		unique case (slot)
			5'd0:  c = 3'd4;
			5'd1:  c = 3'd6;
			5'd2:  c = 3'd7;
			5'd3:  c = 3'd5;
			5'd4:  c = 3'd2;
			5'd5:  c = 3'd0;
			5'd6:  c = 3'd1;
			5'd7:  c = 3'd3;
			5'd8:  c = 3'd6;
			5'd9:  c = 3'd2;
			5'd10: c = 3'd5;
			5'd11: c = 3'd1;
			5'd12: c = 3'd0;
			5'd13: c = 3'd4;
			5'd14: c = 3'd3;
			5'd15: c = 3'd7;
			5'd16: c = 3'd7;
			5'd17: c = 3'd5;
			5'd18: c = 3'd3;
			5'd19: c = 3'd1;
			5'd20: c = 3'd0;
			5'd21: c = 3'd2;
			5'd22: c = 3'd4;
			5'd23: c = 3'd6;
			default: c = 3'd0;
		endcase
		return c;
	endfunction
endpackage

/* rtl/core/bvx_if.sv */
// Segment and vertex channel interfaces.
`timescale 1ns / 1ps
interface bvx_seg_if;
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    start_x;
	logic signed [31:0]    start_y;
	logic signed [31:0]    start_z;
	logic signed [31:0]    end_x;
	logic signed [31:0]    end_y;
	logic signed [31:0]    end_z;

	modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		input ready);
	modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready);
endinterface

interface bvx_vtx_if;
	logic               valid;
	logic               ready;
	logic [4:0]         vertex_slot;
	logic signed [31:0] corner_x;
	logic signed [31:0] corner_y;
	logic signed [31:0] corner_z;
	logic               degenerate;
	logic               last_vertex;

	modport source (output valid, vertex_slot, corner_x, corner_y, corner_z, degenerate,
		last_vertex, input ready);
	modport sink (input valid, vertex_slot, corner_x, corner_y, corner_z, degenerate,
		last_vertex, output ready);
endinterface

/* rtl/core/segment_to_bar_vertices.sv */
// Top level: square bar vertices around a 3-D segment, Q16.16.
//
//   channel   dir   handshake        payload
//   seg       in    valid/ready      start_x..end_z, 6 x 32 bit signed
//   vtx       out   valid/ready      vertex_slot, corner_x/y/z, degenerate, last_vertex
//   cfg       in    cfg_we           cfg_data = half_width, 31 bit
//
// Each segment yields 24 vertex transfers, one per cycle while vtx is ready.
// The front end steps through fit shifts (one bit a cycle), 6 cross-product
// steps, then for each of the two offsets 3 square steps, a bit-serial square
// root, a bit-serial divide and a multiply by half_width.
// A degenerate segment goes from the fit step straight to the push state.
// A two-entry job queue and a held input let intake run while vertices drain.
// Reset clears control and loads half_width with 655; stalls on vtx hold data.
`timescale 1ns / 1ps
module segment_to_bar_vertices #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [30:0] cfg_data,
	bvx_seg_if.sink     seg,
	bvx_vtx_if.source   vtx
);
	logic [30:0]   hw_q;
	bvx_pkg::job_t f_job, b_job;
	logic          f_valid, f_ready, b_valid, b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hw_q <= bvx_pkg::HW_RESET;
		else if (cfg_we) hw_q <= cfg_data;
	end

	bvx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_width (hw_q),
		.seg        (seg),
		.job        (f_job),
		.job_valid  (f_valid),
		.job_ready  (f_ready)
	);

	bvx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_job    (f_job),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.out_job   (b_job),
		.out_valid (b_valid),
		.out_ready (b_ready)
	);

	bvx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (b_job),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.vtx       (vtx)
	);
endmodule

/* rtl/core/bvx_front.sv */
// Front end: segment intake and iterative offset computation.
`timescale 1ns / 1ps
module bvx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [30:0]       half_width,
	bvx_seg_if.sink           seg,
	output bvx_pkg::job_t     job,
	output logic              job_valid,
	input  logic              job_ready
);
	function automatic logic [41:0] mag_of(input logic signed [42:0] v);
		logic [42:0] a;
		a = v[42] ? 43'(-v) : v;
		return a[41:0];
	endfunction

	function automatic logic signed [20:0] to_s21(input logic [41:0] m, input logic n);
		logic signed [20:0] s;
		s = {1'b0, m[19:0]};
		return n ? -s : s;
	endfunction

	localparam logic [62:0] RND = 63'd1 << 29;

	bvx_pkg::front_state_t state_q, state_d;
	bvx_pkg::fit_sel_t     fit_sel_q;
	logic                  hold_valid_q;
	logic                  take;
	logic [4:0]            cnt_q;
	logic                  vec_q;

	logic signed [31:0] hp1_q [3];
	logic signed [31:0] hp2_q [3];
	logic signed [31:0] p1_q  [3];
	logic signed [31:0] p2_q  [3];
	logic signed [32:0] d_q   [3];
	logic signed [32:0] d_new [3];
	logic [41:0]        mag_q [3];
	logic               neg_q [3];
	logic signed [20:0] ds_q  [3];
	logic signed [20:0] t1s_q [3];
	logic signed [20:0] t2s_q [3];
	logic signed [42:0] t2_q  [3];
	logic signed [42:0] acc_q;
	logic [41:0]        sq_q;
	logic [63:0]        sx_q;
	logic [32:0]        rem_q;
	logic [31:0]        root_q;
	logic [31:0]        drem_q [3];
	logic [31:0]        dq_q   [3];
	logic signed [33:0] off1_q [3];
	logic signed [33:0] off2_q [3];
	logic               degen_q;

	logic               fit_zero, fit_hi, fit_lo, fit_ok;
	logic signed [42:0] t1_v [3];
	logic signed [42:0] t2_v [3];
	logic signed [20:0] xa, xb;
	logic signed [41:0] xprod;
	logic signed [42:0] cross_sum;
	logic signed [20:0] v_sel [3];
	logic [19:0]        vm [3];
	logic               vneg [3];
	logic [39:0]        sqp;
	logic [41:0]        sq_next;
	logic [34:0]        sr2, strial, sdiff;
	logic               sge;
	logic [32:0]        rem_next;
	logic [31:0]        root_next;
	logic [61:0]        num [3];
	logic [32:0]        dr2 [3];
	logic [32:0]        ddiff [3];
	logic               dge [3];
	logic [61:0]        mprod;
	logic [62:0]        msum;
	logic signed [33:0] offv;

	assign seg.ready = !hold_valid_q;

	always_comb begin
		fit_zero = 1'b1;
		fit_hi   = 1'b0;
		fit_lo   = 1'b1;
		for (int i = 0; i < 3; i++) begin
			d_new[i] = {hp2_q[i][31], hp2_q[i]} - {hp1_q[i][31], hp1_q[i]};
			if (mag_q[i] != '0) fit_zero = 1'b0;
			if (mag_q[i][41:20] != '0) fit_hi = 1'b1;
			if (mag_q[i][41:19] != '0) fit_lo = 1'b0;
		end
		fit_ok = !fit_zero && !fit_hi && !fit_lo;
		if (d_q[1] < d_q[0]) begin
			t1_v[0] = -{{10{d_q[2][32]}}, d_q[2]};
			t1_v[1] = '0;
			t1_v[2] = {{10{d_q[0][32]}}, d_q[0]};
		end else begin
			t1_v[0] = '0;
			t1_v[1] = {{10{d_q[2][32]}}, d_q[2]};
			t1_v[2] = -{{10{d_q[1][32]}}, d_q[1]};
		end
	end

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin xa = ds_q[1]; xb = t1s_q[2]; end
			3'd1: begin xa = ds_q[2]; xb = t1s_q[1]; end
			3'd2: begin xa = ds_q[2]; xb = t1s_q[0]; end
			3'd3: begin xa = ds_q[0]; xb = t1s_q[2]; end
			3'd4: begin xa = ds_q[0]; xb = t1s_q[1]; end
			3'd5: begin xa = ds_q[1]; xb = t1s_q[0]; end
			default: begin xa = '0; xb = '0; end
		endcase
		xprod = xa * xb;
		cross_sum = cnt_q[0] ? (acc_q - xprod) : 43'(xprod);
		t2_v[0] = t2_q[0];
		t2_v[1] = t2_q[1];
		t2_v[2] = cross_sum;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v_sel[i] = vec_q ? t2s_q[i] : t1s_q[i];
			vneg[i]  = v_sel[i][20];
			vm[i]    = vneg[i] ? 20'(-v_sel[i]) : v_sel[i][19:0];
		end
		sqp     = vm[cnt_q[1:0]] * vm[cnt_q[1:0]];
		sq_next = sq_q + {2'b00, sqp};

		sr2       = {rem_q, sx_q[63:62]};
		strial    = {1'b0, root_q, 2'b01};
		sge       = sr2 >= strial;
		sdiff     = sr2 - strial;
		rem_next  = sge ? sdiff[32:0] : sr2[32:0];
		root_next = {root_q[30:0], sge};

		for (int i = 0; i < 3; i++) begin
			num[i]   = {1'b0, vm[i], 41'd0} + {31'd0, root_next[31:1]};
			dr2[i]   = {drem_q[i], dq_q[i][31]};
			dge[i]   = dr2[i] >= {1'b0, root_q};
			ddiff[i] = dr2[i] - {1'b0, root_q};
		end

		mprod = dq_q[cnt_q[1:0]][30:0] * half_width;
		msum  = {1'b0, mprod} + RND;
		offv  = vneg[cnt_q[1:0]] ? -{1'b0, msum[62:30]} : {1'b0, msum[62:30]};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bvx_pkg::ST_IDLE: begin
				if (hold_valid_q) state_d = bvx_pkg::ST_FIT;
			end
			bvx_pkg::ST_FIT: begin
				if (fit_zero) state_d = bvx_pkg::ST_PUSH;
				else if (fit_ok) begin
					case (fit_sel_q)
						bvx_pkg::FIT_T1: state_d = bvx_pkg::ST_CROSS;
						bvx_pkg::FIT_T2: state_d = bvx_pkg::ST_SQ;
						default:         state_d = bvx_pkg::ST_FIT;
					endcase
				end
			end
			bvx_pkg::ST_CROSS: begin
				if (cnt_q == 5'd5) state_d = bvx_pkg::ST_FIT;
			end
			bvx_pkg::ST_SQ: begin
				if (cnt_q == 5'd2) state_d = bvx_pkg::ST_SQRT;
			end
			bvx_pkg::ST_SQRT: begin
				if (cnt_q == 5'd31) state_d = bvx_pkg::ST_DIV;
			end
			bvx_pkg::ST_DIV: begin
				if (cnt_q == 5'd31) state_d = bvx_pkg::ST_MUL;
			end
			bvx_pkg::ST_MUL: begin
				if (cnt_q == 5'd2) state_d = vec_q ? bvx_pkg::ST_PUSH : bvx_pkg::ST_SQ;
			end
			bvx_pkg::ST_PUSH: begin
				if (job_ready) state_d = bvx_pkg::ST_IDLE;
			end
			default: state_d = bvx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		take      = (state_q == bvx_pkg::ST_IDLE) && hold_valid_q;
		job_valid = (state_q == bvx_pkg::ST_PUSH);
		for (int i = 0; i < 3; i++) begin
			job.p1[i] = p1_q[i];
			job.p2[i] = p2_q[i];
			job.o1[i] = off1_q[i];
			job.o2[i] = off2_q[i];
		end
		job.degen = degen_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bvx_pkg::ST_IDLE;
			hold_valid_q <= 1'b0;
			cnt_q        <= '0;
			vec_q        <= 1'b0;
			fit_sel_q    <= bvx_pkg::FIT_D;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (seg.valid && seg.ready) hold_valid_q <= 1'b1;
			else if (take) hold_valid_q <= 1'b0;
			if (take) fit_sel_q <= bvx_pkg::FIT_D;
			else if (state_q == bvx_pkg::ST_FIT && fit_ok && fit_sel_q == bvx_pkg::FIT_D)
				fit_sel_q <= bvx_pkg::FIT_T1;
			else if (state_q == bvx_pkg::ST_CROSS && cnt_q == 5'd5)
				fit_sel_q <= bvx_pkg::FIT_T2;
			if (state_q == bvx_pkg::ST_FIT && fit_ok && fit_sel_q == bvx_pkg::FIT_T2)
				vec_q <= 1'b0;
			else if (state_q == bvx_pkg::ST_MUL && cnt_q == 5'd2)
				vec_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (seg.valid && seg.ready) begin
			hp1_q[0] <= seg.start_x;
			hp1_q[1] <= seg.start_y;
			hp1_q[2] <= seg.start_z;
			hp2_q[0] <= seg.end_x;
			hp2_q[1] <= seg.end_y;
			hp2_q[2] <= seg.end_z;
		end
		case (state_q)
			bvx_pkg::ST_IDLE: begin
				degen_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					p1_q[i]   <= hp1_q[i];
					p2_q[i]   <= hp2_q[i];
					d_q[i]    <= d_new[i];
					mag_q[i]  <= mag_of({{10{d_new[i][32]}}, d_new[i]});
					neg_q[i]  <= d_new[i][32];
					off1_q[i] <= '0;
					off2_q[i] <= '0;
				end
			end
			bvx_pkg::ST_FIT: begin
				if (fit_zero) degen_q <= 1'b1;
				else if (fit_ok) begin
					for (int i = 0; i < 3; i++) begin
						case (fit_sel_q)
							bvx_pkg::FIT_D: begin
								ds_q[i]  <= to_s21(mag_q[i], neg_q[i]);
								mag_q[i] <= mag_of(t1_v[i]);
								neg_q[i] <= t1_v[i][42];
							end
							bvx_pkg::FIT_T1: t1s_q[i] <= to_s21(mag_q[i], neg_q[i]);
							default:         t2s_q[i] <= to_s21(mag_q[i], neg_q[i]);
						endcase
					end
					sq_q <= '0;
				end else begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= fit_hi ? (mag_q[i] >> 1) : (mag_q[i] << 1);
				end
			end
			bvx_pkg::ST_CROSS: begin
				acc_q <= cross_sum;
				if (cnt_q[0]) t2_q[cnt_q[2:1]] <= cross_sum;
				if (cnt_q == 5'd5) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= mag_of(t2_v[i]);
						neg_q[i] <= t2_v[i][42];
					end
				end
			end
			bvx_pkg::ST_SQ: begin
				sq_q <= sq_next;
				if (cnt_q == 5'd2) begin
					sx_q   <= {sq_next, 22'd0};
					rem_q  <= '0;
					root_q <= '0;
				end
			end
			bvx_pkg::ST_SQRT: begin
				sx_q   <= {sx_q[61:0], 2'b00};
				rem_q  <= rem_next;
				root_q <= root_next;
				if (cnt_q == 5'd31) begin
					for (int i = 0; i < 3; i++) begin
						drem_q[i] <= {2'b00, num[i][61:32]};
						dq_q[i]   <= num[i][31:0];
					end
				end
			end
			bvx_pkg::ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= dge[i] ? ddiff[i][31:0] : dr2[i][31:0];
					dq_q[i]   <= {dq_q[i][30:0], dge[i]};
				end
			end
			bvx_pkg::ST_MUL: begin
				if (vec_q) off2_q[cnt_q[1:0]] <= offv;
				else off1_q[cnt_q[1:0]] <= offv;
				sq_q <= '0;
			end
			default: ;
		endcase
	end
endmodule

/* rtl/core/bvx_queue.sv */
// Job queue between the front end and the vertex emitter.
`timescale 1ns / 1ps
module bvx_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bvx_pkg::job_t in_job,
	input  logic          in_valid,
	output logic          in_ready,
	output bvx_pkg::job_t out_job,
	output logic          out_valid,
	input  logic          out_ready
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	bvx_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != CNT_W'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_job   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_job;
	end
endmodule

/* rtl/core/bvx_back.sv */
// Back end: emits the 24 saturated corner vertices of each job.
`timescale 1ns / 1ps
module bvx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  bvx_pkg::job_t job,
	input  logic          job_valid,
	output logic          job_ready,
	bvx_vtx_if.source     vtx
);
	bvx_pkg::job_t      cur_q;
	logic               cur_valid_q;
	logic [4:0]         slot_q;
	logic               out_valid_q;
	logic [4:0]         slot_out_q;
	logic signed [31:0] cx_q [3];
	logic               degen_out_q, last_out_q;
	logic               adv, last;
	logic [2:0]         combo;
	logic signed [31:0] base [3];
	logic signed [33:0] ofs  [3];
	logic signed [34:0] sum  [3];
	logic signed [31:0] sat  [3];

	assign adv       = cur_valid_q && (!out_valid_q || vtx.ready);
	assign last      = (slot_q == bvx_pkg::LAST_SLOT);
	assign job_ready = !cur_valid_q || (adv && last);

	always_comb begin
		combo = bvx_pkg::slot_combo(slot_q);
		for (int i = 0; i < 3; i++) begin
			base[i] = combo[bvx_pkg::CMB_P2] ? cur_q.p2[i] : cur_q.p1[i];
			ofs[i]  = combo[bvx_pkg::CMB_T2] ? cur_q.o2[i] : cur_q.o1[i];
			sum[i]  = combo[bvx_pkg::CMB_SUB]
				? ({{3{base[i][31]}}, base[i]} - {ofs[i][33], ofs[i]})
				: ({{3{base[i][31]}}, base[i]} + {ofs[i][33], ofs[i]});
			if (sum[i][34:31] == 4'b0000 || sum[i][34:31] == 4'b1111)
				sat[i] = sum[i][31:0];
			else
				sat[i] = sum[i][34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_ready && job_valid) begin
				cur_valid_q <= 1'b1;
				slot_q      <= '0;
			end else if (adv) begin
				if (last) cur_valid_q <= 1'b0;
				else slot_q <= slot_q + 5'd1;
			end
			if (adv) out_valid_q <= 1'b1;
			else if (vtx.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) cur_q <= job;
		if (adv) begin
			slot_out_q  <= slot_q;
			degen_out_q <= cur_q.degen;
			last_out_q  <= last;
			for (int i = 0; i < 3; i++) cx_q[i] <= sat[i];
		end
	end

	assign vtx.valid       = out_valid_q;
	assign vtx.vertex_slot = slot_out_q;
	assign vtx.corner_x    = cx_q[0];
	assign vtx.corner_y    = cx_q[1];
	assign vtx.corner_z    = cx_q[2];
	assign vtx.degenerate  = degen_out_q;
	assign vtx.last_vertex = last_out_q;
endmodule

/* rtl/core/bvx_check.sv */
// Port-level checker for the vertex channel, bound to the top level.
`timescale 1ns / 1ps
`include "segment_to_bar_vertices_defines.svh"
module bvx_check (
	input logic       clk,
	input logic       arst_n,
	input logic       vtx_valid,
	input logic       vtx_ready,
	input logic [4:0] vtx_slot,
	input logic       vtx_last,
	input logic       vtx_degen
);
	logic [4:0] exp_q;
	logic       deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			deg_q <= 1'b0;
		end else if (vtx_valid && vtx_ready) begin
			exp_q <= (vtx_slot == bvx_pkg::LAST_SLOT) ? 5'd0 : vtx_slot + 5'd1;
			if (vtx_slot == 5'd0) deg_q <= vtx_degen;
		end
	end

	`BVX_ASSERT_IMPL(a_slot_order, vtx_valid, vtx_slot == exp_q)
	`BVX_ASSERT_IMPL(a_last_flag, vtx_valid, vtx_last == (vtx_slot == bvx_pkg::LAST_SLOT))
	`BVX_ASSERT_IMPL(a_degen_run, vtx_valid && vtx_slot != 5'd0, vtx_degen == deg_q)
	`BVX_ASSERT_NEXT(a_stall_hold, vtx_valid && !vtx_ready, vtx_valid && $stable(vtx_slot))
endmodule

bind segment_to_bar_vertices bvx_check u_bvx_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.vtx_valid (vtx.valid),
	.vtx_ready (vtx.ready),
	.vtx_slot  (vtx.vertex_slot),
	.vtx_last  (vtx.last_vertex),
	.vtx_degen (vtx.degenerate)
);

/* test/segment_to_bar_vertices_tb.sv */
// Testbench for the segment-to-bar vertex block: directed, width sweep, backpressure, random.
`timescale 1ns / 1ps
module segment_to_bar_vertices_tb;
	localparam int NUM_SLOTS = 24;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 260;
	localparam logic [30:0] HW_MAX = 31'h7FFF_FFFF;
	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

	localparam logic [2:0] CORNER_ORDER [NUM_SLOTS] = '{
		3'd4, 3'd6, 3'd7, 3'd5, 3'd2, 3'd0, 3'd1, 3'd3, 3'd6, 3'd2, 3'd5, 3'd1,
		3'd0, 3'd4, 3'd3, 3'd7, 3'd7, 3'd5, 3'd3, 3'd1, 3'd0, 3'd2, 3'd4, 3'd6
	};

	typedef logic signed [2:0][63:0] vec_t;

	typedef struct packed {
		bvx_pkg::coord_t sx, sy, sz, ex, ey, ez;
	} segment_t;

	typedef struct packed {
		logic [4:0]      slot;
		bvx_pkg::coord_t x, y, z;
		logic            degen;
		logic            last;
	} vertex_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [30:0] cfg_data;

	bvx_seg_if seg ();
	bvx_vtx_if vtx ();

	segment_to_bar_vertices i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.seg      (seg.sink),
		.vtx      (vtx.source)
	);

	vertex_t     expected_vertices [$];
	logic [30:0] bar_half_width;
	int          mismatch_count;
	int          segments_sent;
	int          vertices_seen;
	int          hold_left;
	int          stall_left;
	int          idle_cycles;
	bit          quiet;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [63:0] mag64(input longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit normalize_shift(input vec_t v, output vec_t o);
		logic [2:0][63:0] m;
		logic [63:0] mx;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag64($signed(v[i]));
			if (m[i] > mx)
				mx = m[i];
		end
		o = '0;
		if (mx == 0)
			return 1'b0;
		while (mx >= (64'd1 << 20)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
		end
		while (mx < (64'd1 << 19)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		for (int i = 0; i < 3; i++)
			o[i] = ($signed(v[i]) < 0) ? -m[i] : m[i];
		return 1'b1;
	endfunction

	function automatic vec_t width_offset(input vec_t v, input logic [30:0] hw);
		logic [2:0][63:0] m;
		logic [63:0] sq, n, u, off;
		vec_t o;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag64($signed(v[i]));
			sq += m[i] * m[i];
		end
		n = int_sqrt(sq << 22);
		if (n == 0)
			n = 1;
		for (int i = 0; i < 3; i++) begin
			u = ((m[i] << 41) + (n >> 1)) / n;
			off = (u * {33'd0, hw} + (64'd1 << 29)) >> 30;
			o[i] = ($signed(v[i]) < 0) ? -off : off;
		end
		return o;
	endfunction

	function automatic bvx_pkg::coord_t sat32(input longint a);
		if (a > 64'sh7FFF_FFFF)
			return C_MAX;
		if (a < -64'sh8000_0000)
			return C_MIN;
		return a[31:0];
	endfunction

	function automatic void predict_bar(input segment_t s);
		vec_t p1, p2, d, t1, ds, t1s, t2, t2s, o1, o2, base, ofs;
		logic degen;
		vertex_t v;
		logic [2:0] c;
		longint sum;
		p1[0] = s.sx; p1[1] = s.sy; p1[2] = s.sz;
		p2[0] = s.ex; p2[1] = s.ey; p2[2] = s.ez;
		for (int i = 0; i < 3; i++)
			d[i] = $signed(p2[i]) - $signed(p1[i]);
		if ($signed(d[1]) < $signed(d[0])) begin
			t1[0] = -$signed(d[2]); t1[1] = 0; t1[2] = d[0];
		end else begin
			t1[0] = 0; t1[1] = d[2]; t1[2] = -$signed(d[1]);
		end
		o1 = '0;
		o2 = '0;
		degen = 1'b0;
		if (!normalize_shift(d, ds) || !normalize_shift(t1, t1s)) begin
			degen = 1'b1;
		end else begin
			t2[0] = $signed(ds[1]) * $signed(t1s[2]) - $signed(ds[2]) * $signed(t1s[1]);
			t2[1] = $signed(ds[2]) * $signed(t1s[0]) - $signed(ds[0]) * $signed(t1s[2]);
			t2[2] = $signed(ds[0]) * $signed(t1s[1]) - $signed(ds[1]) * $signed(t1s[0]);
			if (!normalize_shift(t2, t2s)) begin
				degen = 1'b1;
			end else begin
				o1 = width_offset(t1s, bar_half_width);
				o2 = width_offset(t2s, bar_half_width);
			end
		end
		for (int k = 0; k < NUM_SLOTS; k++) begin
			c = CORNER_ORDER[k];
			base = c[bvx_pkg::CMB_P2] ? p2 : p1;
			ofs = c[bvx_pkg::CMB_T2] ? o2 : o1;
			v.slot = k[4:0];
			sum = c[bvx_pkg::CMB_SUB] ? $signed(base[0]) - $signed(ofs[0])
				: $signed(base[0]) + $signed(ofs[0]);
			v.x = sat32(sum);
			sum = c[bvx_pkg::CMB_SUB] ? $signed(base[1]) - $signed(ofs[1])
				: $signed(base[1]) + $signed(ofs[1]);
			v.y = sat32(sum);
			sum = c[bvx_pkg::CMB_SUB] ? $signed(base[2]) - $signed(ofs[2])
				: $signed(base[2]) + $signed(ofs[2]);
			v.z = sat32(sum);
			v.degen = degen;
			v.last = (k == NUM_SLOTS - 1);
			expected_vertices.push_back(v);
		end
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic send_segment(input segment_t s);
		int gap;
		gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg.valid   <= 1'b1;
		seg.start_x <= s.sx;
		seg.start_y <= s.sy;
		seg.start_z <= s.sz;
		seg.end_x   <= s.ex;
		seg.end_y   <= s.ey;
		seg.end_z   <= s.ez;
		do
			@(posedge clk);
		while (!seg.ready);
		predict_bar(s);
		segments_sent++;
	endtask

	task automatic end_burst();
		seg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		end_burst();
		wait (expected_vertices.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_half_width(input logic [30:0] hw);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= hw;
		@(posedge clk);
		cfg_we <= 1'b0;
		bar_half_width = hw;
		@(posedge clk);
	endtask

	function automatic segment_t seg_of(input bvx_pkg::coord_t sx, sy, sz, ex, ey, ez);
		segment_t s;
		s.sx = sx; s.sy = sy; s.sz = sz; s.ex = ex; s.ey = ey; s.ez = ez;
		return s;
	endfunction

	function automatic segment_t random_segment();
		segment_t s;
		int kind;
		bvx_pkg::coord_t dx, dy, dz;
		kind = $urandom_range(0, 9);
		s = seg_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (kind >= 4) begin
			s.sx = $signed($urandom) >>> $urandom_range(8, 28);
			s.sy = $signed($urandom) >>> $urandom_range(8, 28);
			s.sz = $signed($urandom) >>> $urandom_range(8, 28);
			dx = $signed($urandom) >>> $urandom_range(4, 30);
			dy = $signed($urandom) >>> $urandom_range(4, 30);
			dz = $signed($urandom) >>> $urandom_range(4, 30);
			s.ex = s.sx + dx; s.ey = s.sy + dy; s.ez = s.sz + dz;
		end
		if (kind == 3) begin
			s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
		end
		if (kind == 2) begin
			s.ey = s.sy; s.ez = s.sz;
		end
		return s;
	endfunction

	task automatic test_directed();
		bvx_pkg::coord_t a;
		a = 32'sd65536;
		send_segment(seg_of(0, 0, 0, 0, 0, 0));
		send_segment(seg_of(C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX));
		send_segment(seg_of(0, 0, 0, a, 0, 0));
		send_segment(seg_of(0, 0, 0, -a, 0, 0));
		send_segment(seg_of(0, 0, 0, 0, a, 0));
		send_segment(seg_of(0, 0, 0, 0, -a, 0));
		send_segment(seg_of(0, 0, 0, 0, 0, a));
		send_segment(seg_of(0, 0, 0, 0, 0, -a));
		send_segment(seg_of(0, 0, 0, a, a, a));
		send_segment(seg_of(0, 0, 0, 1, 0, 1));
		send_segment(seg_of(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
		send_segment(seg_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
		send_segment(seg_of(C_MIN, C_MAX, 0, C_MAX, C_MIN, 32'sd1));
		send_segment(seg_of(C_MAX, C_MAX, C_MAX, C_MAX - a, C_MAX - a, C_MAX - 2 * a));
		send_segment(seg_of(C_MIN, C_MIN, C_MIN, C_MIN + a, C_MIN + a, C_MIN + 2 * a));
		send_segment(seg_of(-32'sd1, -32'sd1, -32'sd1, 32'sd3, -32'sd7, 32'sd2));
		end_burst();
	endtask

	task automatic test_half_width_sweep();
		logic [30:0] widths [5];
		bvx_pkg::coord_t a;
		a = 32'sd65536;
		widths = '{31'd0, HW_MAX, 31'd1, 31'd65536, 31'(bvx_pkg::HW_RESET)};
		foreach (widths[w]) begin
			write_half_width(widths[w]);
			send_segment(seg_of(0, 0, 0, a, 2 * a, -a));
			send_segment(seg_of(C_MAX, C_MAX, C_MAX, C_MAX - a, C_MAX - a, C_MAX - 2 * a));
			send_segment(seg_of(C_MIN, C_MIN, C_MIN, C_MIN + a, C_MIN + 3 * a, C_MIN + a));
			send_segment(random_segment());
		end
		end_burst();
	endtask

	task automatic test_backpressure();
		wait_drained();
		hold_left = 1500;
		for (int i = 0; i < 8; i++)
			send_segment(random_segment());
		wait_drained();
		for (int i = 0; i < 4; i++)
			send_segment(random_segment());
		end_burst();
	endtask

	task automatic test_random();
		for (int i = 0; i < 82; i++) begin
			if (i % 40 == 39)
				write_half_width($urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(1, 1 << 18)));
			if (i == 70)
				quiet = 1'b1;
			send_segment(random_segment());
		end
		end_burst();
	endtask

	always @(posedge clk) begin
		vertex_t want;
		if (arst_n && vtx.valid && vtx.ready) begin
			vertices_seen++;
			if (expected_vertices.size() == 0) begin
				report_mismatch("unexpected vertex slot", vtx.vertex_slot, -1);
			end else begin
				want = expected_vertices.pop_front();
				if (vtx.vertex_slot !== want.slot)
					report_mismatch("vertex_slot", vtx.vertex_slot, want.slot);
				if (vtx.corner_x !== want.x)
					report_mismatch("corner_x", vtx.corner_x, want.x);
				if (vtx.corner_y !== want.y)
					report_mismatch("corner_y", vtx.corner_y, want.y);
				if (vtx.corner_z !== want.z)
					report_mismatch("corner_z", vtx.corner_z, want.z);
				if (vtx.degenerate !== want.degen)
					report_mismatch("degenerate", vtx.degenerate, want.degen);
				if (vtx.last_vertex !== want.last)
					report_mismatch("last_vertex", vtx.last_vertex, want.last);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			vtx.ready <= 1'b0;
		end else if (quiet) begin
			vtx.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			vtx.ready <= 1'b0;
		end else if ($urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			vtx.ready <= 1'b0;
		end else begin
			vtx.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((seg.valid && seg.ready) || (vtx.valid && vtx.ready) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d vertices pending",
				idle_cycles, expected_vertices.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		seg.valid = 1'b0;
		seg.start_x = '0;
		seg.start_y = '0;
		seg.start_z = '0;
		seg.end_x = '0;
		seg.end_y = '0;
		seg.end_z = '0;
		vtx.ready = 1'b0;
		bar_half_width = bvx_pkg::HW_RESET;
		mismatch_count = 0;
		segments_sent = 0;
		vertices_seen = 0;
		hold_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_half_width_sweep();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_vertices.size() != 0)
			report_mismatch("vertices left over", expected_vertices.size(), 0);
		$display("covered %0d segments and %0d vertex transfers: axis, zero-length,",
			segments_sent, vertices_seen);
		$display("saturating and random segments over several half-width settings");
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bvx_pkg.sv
rtl/core/bvx_if.sv
rtl/core/bvx_front.sv
rtl/core/bvx_queue.sv
rtl/core/bvx_back.sv
rtl/core/segment_to_bar_vertices.sv
rtl/core/bvx_check.sv
test/segment_to_bar_vertices_tb.sv
